FILE: rtl/core/ll1c_pkg.sv
// ll1c_pkg: grammar tables, symbol codes and shared types of the ll1 token checker
// no dependencies

package ll1c_pkg;

	localparam int StackDepthDefault = 64;
	localparam int TokW = 5;
	localparam int SymW = 6;
	localparam int StatW = 3;

	// terminal codes
	localparam logic [SymW-1:0] T_ID = 6'd0;
	localparam logic [SymW-1:0] T_INT = 6'd1;
	localparam logic [SymW-1:0] T_FLOAT = 6'd2;
	localparam logic [SymW-1:0] T_STR = 6'd3;
	localparam logic [SymW-1:0] T_ADD = 6'd4;
	localparam logic [SymW-1:0] T_MUL = 6'd5;
	localparam logic [SymW-1:0] T_CMP = 6'd6;
	localparam logic [SymW-1:0] T_ASG = 6'd7;
	localparam logic [SymW-1:0] T_IF = 6'd8;
	localparam logic [SymW-1:0] T_THEN = 6'd9;
	localparam logic [SymW-1:0] T_ELSE = 6'd10;
	localparam logic [SymW-1:0] T_WHILE = 6'd11;
	localparam logic [SymW-1:0] T_DO = 6'd12;
	localparam logic [SymW-1:0] T_READ = 6'd13;
	localparam logic [SymW-1:0] T_WRITE = 6'd14;
	localparam logic [SymW-1:0] T_LP = 6'd15;
	localparam logic [SymW-1:0] T_RP = 6'd16;
	localparam logic [SymW-1:0] T_LB = 6'd17;
	localparam logic [SymW-1:0] T_RB = 6'd18;
	localparam logic [SymW-1:0] T_SEMI = 6'd19;
	localparam logic [SymW-1:0] T_COMMA = 6'd20;
	localparam logic [SymW-1:0] T_END = 6'd21;

	// nonterminal codes
	localparam logic [SymW-1:0] N_PROG = 6'd32;
	localparam logic [SymW-1:0] N_SLIST = 6'd33;
	localparam logic [SymW-1:0] N_STAIL = 6'd34;
	localparam logic [SymW-1:0] N_STMT = 6'd35;
	localparam logic [SymW-1:0] N_IFT = 6'd36;
	localparam logic [SymW-1:0] N_VAR = 6'd37;
	localparam logic [SymW-1:0] N_VEXT = 6'd38;
	localparam logic [SymW-1:0] N_IDXT = 6'd39;
	localparam logic [SymW-1:0] N_EXPR = 6'd40;
	localparam logic [SymW-1:0] N_ETAIL = 6'd41;
	localparam logic [SymW-1:0] N_TTAIL = 6'd42;
	localparam logic [SymW-1:0] N_FACT = 6'd43;
	localparam logic [SymW-1:0] N_COND = 6'd44;
	localparam logic [SymW-1:0] N_WARG = 6'd45;

	typedef enum logic [StatW-1:0] {
		ST_CONSUMED = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_NO_ENTRY = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_PUSH,
		BK_DONE
	} bk_state_t;

	localparam logic [4:0] RULE_NONE = 5'd0;
	localparam logic [4:0] RULE_EMPTY = 5'd8;

	// classified token handed from front to back
	typedef struct packed {
		logic [TokW-1:0] tok;
		logic            is_term;  // code names a real terminal
	} tok_item_t;

	function automatic logic [2:0] rule_len(input logic [4:0] r);
		unique case (r)
			5'd1, 5'd26, 5'd27, 5'd29: rule_len = 3'd1;
			5'd7, 5'd14, 5'd15, 5'd17, 5'd22, 5'd25: rule_len = 3'd2;
			5'd20, 5'd21, 5'd23, 5'd24, 5'd28: rule_len = 3'd3;
			5'd9, 5'd11, 5'd12, 5'd13, 5'd16, 5'd19: rule_len = 3'd4;
			5'd2, 5'd4, 5'd5, 5'd6, 5'd10, 5'd18: rule_len = 3'd5;
			5'd3: rule_len = 3'd6;
			default: rule_len = 3'd0;
		endcase
	endfunction

	// right-hand side symbol i (0 = leftmost)
	function automatic logic [SymW-1:0] rule_sym(input logic [4:0] r, input logic [2:0] i);
		logic [SymW-1:0] s [6];
		s = '{default: T_ID};
		unique case (r)
			5'd1: s[0] = N_SLIST;
			5'd2: s = '{T_ID, N_VEXT, T_ASG, N_EXPR, N_STAIL, T_ID};
			5'd3: s = '{T_IF, N_COND, T_THEN, N_STMT, N_IFT, N_STAIL};
			5'd4: s = '{T_WHILE, N_COND, T_DO, N_STMT, N_STAIL, T_ID};
			5'd5: s = '{T_READ, T_LP, N_VAR, T_RP, N_STAIL, T_ID};
			5'd6: s = '{T_WRITE, T_LP, N_WARG, T_RP, N_STAIL, T_ID};
			5'd7: s = '{T_SEMI, N_SLIST, T_ID, T_ID, T_ID, T_ID};
			5'd9: s = '{T_ID, N_VEXT, T_ASG, N_EXPR, T_ID, T_ID};
			5'd10: s = '{T_IF, N_COND, T_THEN, N_STMT, N_IFT, T_ID};
			5'd11: s = '{T_WHILE, N_COND, T_DO, N_STMT, T_ID, T_ID};
			5'd12: s = '{T_READ, T_LP, N_VAR, T_RP, T_ID, T_ID};
			5'd13: s = '{T_WRITE, T_LP, N_WARG, T_RP, T_ID, T_ID};
			5'd14: s = '{T_ELSE, N_STMT, T_ID, T_ID, T_ID, T_ID};
			5'd15, 5'd25: s = '{T_ID, N_VEXT, T_ID, T_ID, T_ID, T_ID};
			5'd16: s = '{T_LB, N_EXPR, N_IDXT, T_RB, T_ID, T_ID};
			5'd17: s = '{T_COMMA, N_EXPR, T_ID, T_ID, T_ID, T_ID};
			5'd18: s = '{T_LP, N_EXPR, T_RP, N_TTAIL, N_ETAIL, T_ID};
			5'd19: s = '{T_ID, N_VEXT, N_TTAIL, N_ETAIL, T_ID, T_ID};
			5'd20: s = '{T_INT, N_TTAIL, N_ETAIL, T_ID, T_ID, T_ID};
			5'd21: s = '{T_FLOAT, N_TTAIL, N_ETAIL, T_ID, T_ID, T_ID};
			5'd22: s = '{T_ADD, N_EXPR, T_ID, T_ID, T_ID, T_ID};
			5'd23: s = '{T_MUL, N_FACT, N_TTAIL, T_ID, T_ID, T_ID};
			5'd24: s = '{T_LP, N_EXPR, T_RP, T_ID, T_ID, T_ID};
			5'd26: s[0] = T_INT;
			5'd27: s[0] = T_FLOAT;
			5'd28: s = '{N_EXPR, T_CMP, N_EXPR, T_ID, T_ID, T_ID};
			5'd29: s[0] = T_STR;
			default: s[0] = T_ID;
		endcase
		rule_sym = (i < 3'd6) ? s[i] : T_ID;
	endfunction

	function automatic logic [4:0] predict(input logic [SymW-1:0] nt, input logic [TokW-1:0] t);
		logic [SymW-1:0] tk;
		logic [4:0] r;
		tk = {1'b0, t};
		r = RULE_NONE;
		unique case (nt)
			N_PROG: if (tk == T_ID || tk == T_IF || tk == T_WHILE || tk == T_READ ||
					tk == T_WRITE) r = 5'd1;
			N_SLIST, N_STMT: begin
				if (tk == T_ID) r = 5'd2;
				else if (tk == T_IF) r = 5'd3;
				else if (tk == T_WHILE) r = 5'd4;
				else if (tk == T_READ) r = 5'd5;
				else if (tk == T_WRITE) r = 5'd6;
				if (nt == N_STMT && r != RULE_NONE) r = r + 5'd7;
			end
			N_STAIL: begin
				if (tk == T_SEMI) r = 5'd7;
				else if (tk == T_END || tk == T_ELSE) r = RULE_EMPTY;
			end
			N_IFT: begin
				if (tk == T_ELSE) r = 5'd14;
				else if (tk == T_SEMI || tk == T_END) r = RULE_EMPTY;
			end
			N_VAR: if (tk == T_ID) r = 5'd15;
			N_VEXT: begin
				if (tk == T_LB) r = 5'd16;
				else if (tk == T_ASG || tk == T_ADD || tk == T_MUL || tk == T_CMP ||
					tk == T_THEN || tk == T_DO || tk == T_RP || tk == T_RB ||
					tk == T_SEMI || tk == T_COMMA || tk == T_END || tk == T_ELSE)
					r = RULE_EMPTY;
			end
			N_IDXT: begin
				if (tk == T_COMMA) r = 5'd17;
				else if (tk == T_RB) r = RULE_EMPTY;
			end
			N_EXPR, N_WARG: begin
				if (tk == T_LP) r = 5'd18;
				else if (tk == T_ID) r = 5'd19;
				else if (tk == T_INT) r = 5'd20;
				else if (tk == T_FLOAT) r = 5'd21;
				else if (tk == T_STR && nt == N_WARG) r = 5'd29;
			end
			N_ETAIL: begin
				if (tk == T_ADD) r = 5'd22;
				else if (tk == T_THEN || tk == T_DO || tk == T_RP || tk == T_RB ||
					tk == T_CMP || tk == T_SEMI || tk == T_COMMA || tk == T_END ||
					tk == T_ELSE) r = RULE_EMPTY;
			end
			N_TTAIL: begin
				if (tk == T_MUL) r = 5'd23;
				else if (tk == T_ADD || tk == T_THEN || tk == T_DO || tk == T_RP ||
					tk == T_RB || tk == T_CMP || tk == T_SEMI || tk == T_COMMA ||
					tk == T_END || tk == T_ELSE) r = RULE_EMPTY;
			end
			N_FACT: begin
				if (tk == T_LP) r = 5'd24;
				else if (tk == T_ID) r = 5'd25;
				else if (tk == T_INT) r = 5'd26;
				else if (tk == T_FLOAT) r = 5'd27;
			end
			N_COND: if (tk == T_LP || tk == T_ID || tk == T_INT || tk == T_FLOAT) r = 5'd28;
			default: r = RULE_NONE;
		endcase
		predict = r;
	endfunction

endpackage

FILE: rtl/core/ll1c_front.sv
// ll1c_front: accepts tokens, classifies them and queues them for the parse engine
// depends on ll1c_pkg

module ll1c_front import ll1c_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	input  logic [TokW-1:0] token_kind,
	output logic            q_valid,
	input  logic            q_pop,
	output tok_item_t       q_item
);

	localparam int QDepth = 2;

	tok_item_t   q_mem_q [QDepth];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign ready = (cnt_q != 2'(QDepth));
	assign push = valid && ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q].tok <= token_kind;
			q_mem_q[wr_ptr_q].is_term <= ({1'b0, token_kind} <= T_END);
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: rtl/core/ll1c_back.sv
// ll1c_back: pushdown engine that expands nonterminals and matches terminals
// depends on ll1c_pkg

module ll1c_back import ll1c_pkg::*; #(
	parameter int STACK_DEPTH = StackDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  tok_item_t        q_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [StatW-1:0] status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [SymW-1:0] stk_mem [STACK_DEPTH];
	logic [SymW-1:0] top_q;
	bk_state_t       st_q, st_d;
	logic [DW-1:0]   depth_q, depth_d;
	logic            active_q, active_d;
	logic [4:0]      rule_q, rule_d;
	logic [2:0]      idx_q, idx_d;
	logic [StatW-1:0] status_q, status_d;
	logic            ovalid_q, ovalid_d;
	logic            wr_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [SymW-1:0] wr_data;
	logic [4:0]      rule_c;
	logic [DW:0]     need;

	assign out_valid = ovalid_q;
	assign status = status_q;
	assign rule_c = predict(top_q, q_item.tok);
	assign need = {1'b0, depth_q} - 1'b1 + (DW+1)'(rule_len(rule_c));

	// stack memory, registered read of the top entry with write forwarding
	always_ff @(posedge clk) begin
		if (wr_en) stk_mem[wr_addr] <= wr_data;
		top_q <= (wr_en && wr_addr == rd_addr) ? wr_data : stk_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			depth_q <= '0;
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			depth_q <= depth_d;
			active_q <= active_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		rule_q <= rule_d;
		idx_q <= idx_d;
		status_q <= status_d;
	end

	// sequencer: restart, read top, expand or match, push rule symbols
	always_comb begin
		st_d = st_q;
		depth_d = depth_q;
		active_d = active_q;
		rule_d = rule_q;
		idx_d = idx_q;
		status_d = status_q;
		ovalid_d = ovalid_q && !out_ready;
		q_pop = 1'b0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = T_END;
		rd_addr = AW'(depth_q - 1'b1);
		unique case (st_q)
			BK_IDLE: begin
				if (q_valid && !ovalid_d) begin
					if (!active_q || depth_q == '0) begin
						// fresh parse: end at bottom, program on top
						wr_en = 1'b1;
						wr_addr = '0;
						wr_data = T_END;
						rule_d = 5'd0;
						idx_d = 3'd0;
						depth_d = DW'(1);
						active_d = 1'b1;
						st_d = BK_DONE;
					end else begin
						st_d = BK_READ;
					end
				end
			end
			BK_DONE: begin
				// finish fresh-parse setup by writing program
				wr_en = 1'b1;
				wr_addr = AW'(1);
				wr_data = N_PROG;
				depth_d = DW'(2);
				rd_addr = AW'(1);
				st_d = BK_PUSH;
				idx_d = 3'd0;
				rule_d = 5'd0;
			end
			BK_READ: begin
				if (top_q < 6'd32) begin
					q_pop = 1'b1;
					ovalid_d = 1'b1;
					st_d = BK_IDLE;
					if (q_item.is_term && top_q == {1'b0, q_item.tok}) begin
						depth_d = depth_q - 1'b1;
						status_d = (depth_q == DW'(1)) ? ST_COMPLETE : ST_CONSUMED;
						if (depth_q == DW'(1)) active_d = 1'b0;
					end else begin
						status_d = ST_MISMATCH;
						active_d = 1'b0;
					end
				end else if (rule_c == RULE_NONE) begin
					q_pop = 1'b1;
					ovalid_d = 1'b1;
					status_d = ST_NO_ENTRY;
					active_d = 1'b0;
					st_d = BK_IDLE;
				end else if (need > (DW+1)'(STACK_DEPTH)) begin
					q_pop = 1'b1;
					ovalid_d = 1'b1;
					status_d = ST_OVERFLOW;
					active_d = 1'b0;
					depth_d = depth_q - 1'b1;
					st_d = BK_IDLE;
				end else begin
					depth_d = depth_q - 1'b1;
					rule_d = rule_c;
					idx_d = rule_len(rule_c);
					st_d = BK_PUSH;
					rd_addr = AW'(depth_q - 2'd2);
					if (rule_len(rule_c) == 3'd0 && depth_q == DW'(1)) begin
						// empty stack cannot continue: no entry
						q_pop = 1'b1;
						ovalid_d = 1'b1;
						status_d = ST_NO_ENTRY;
						active_d = 1'b0;
						st_d = BK_IDLE;
					end
				end
			end
			BK_PUSH: begin
				// push one right-hand symbol per cycle, rightmost first
				if (idx_q != 3'd0) begin
					wr_en = 1'b1;
					wr_addr = AW'(depth_q);
					wr_data = rule_sym(rule_q, idx_q - 3'd1);
					depth_d = depth_q + 1'b1;
					idx_d = idx_q - 3'd1;
					rd_addr = AW'(depth_q);
					if (idx_q == 3'd1) st_d = BK_READ;
				end else begin
					rd_addr = AW'(depth_q - 1'b1);
					st_d = BK_READ;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

endmodule

FILE: rtl/core/ll1_pushdown_token_checker.sv
// ll1_pushdown_token_checker: top level of the predictive ll(1) syntax checker
// depends on ll1c_pkg, ll1c_front, ll1c_back
//
// Input channel valid/ready/token_kind takes one token kind per item; output
// channel out_valid/out_ready/status returns exactly one status per item:
// 0 consumed, 1 parse complete, 2 terminal mismatch, 3 no table entry,
// 4 stack overflow. After complete or any error the next token starts a
// new parse on the stack [end, program].
// A token that matches directly is checked against the registered top entry
// and popped; an expansion replaces the top nonterminal by its right-hand
// symbols, pushed rightmost first, and a new parse first writes end and
// program onto the stack. The back engine handles one item at a time: it
// takes the next queued item only once the result register is free.
// A two-entry queue lets the front accept items while the engine works.
// Reset clears the queue, the stack depth and the parse-active flag; stack
// contents need no clearing. If out_ready is low, the result register holds
// and the engine waits before taking the next queued item.

module ll1_pushdown_token_checker import ll1c_pkg::*; #(
	parameter int STACK_DEPTH = StackDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [TokW-1:0]  token_kind,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [StatW-1:0] status
);

	logic      q_valid, q_pop;
	tok_item_t q_item;

	ll1c_front u_front (
		.clk, .arst_n, .valid, .ready, .token_kind,
		.q_valid, .q_pop, .q_item
	);

	ll1c_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid, .out_ready, .status
	);

	// status codes stay in range whenever a result is shown
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= 3'd4))
		else $error("status out of range");

	// an item is popped only when the queue holds one
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// a popped item always raises a result on the next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("item popped without result");

endmodule
